// ----- hdl/ppp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared beat types, register indexes and fixed constants of the projector.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int FIELD_W    = 32;
  localparam int TRIG_FRAC  = 14;
  localparam int FIFO_DEPTH = 4;   // power of two, pointers wrap naturally
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Z     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_OF = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL     = 3'd7;

  localparam logic [31:0] TRIG_RST = 32'h4000_0000;

  typedef struct packed {
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
    logic signed [FIELD_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] screen_x;
    logic signed [FIELD_W-1:0] screen_y;
    logic signed [FIELD_W-1:0] depth;
    logic                      zero_depth;
    logic                      saturated;
  } result_t;

endpackage

// ----- hdl/ppp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_front
// Front pipeline: camera translation and the three rotations, seven stages.
// ----------------------------------------------------------------------------
module ppp_front #(
  parameter int CW = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ppp_pkg::point_t     in_i,
  input  logic [31:0]         cam_x_i,
  input  logic [31:0]         cam_y_i,
  input  logic [31:0]         cam_z_i,
  input  logic [31:0]         trig_x_i,
  input  logic [31:0]         trig_y_i,
  input  logic [31:0]         trig_z_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3*CW:0]       out_o
);
  import ppp_pkg::*;

  localparam int NS = 7;
  localparam int SW = CW + 18;
  localparam int QW = SW - TRIG_FRAC;
  localparam logic signed [SW-1:0] RND = SW'(1) << (TRIG_FRAC - 1);

  function automatic logic signed [CW-1:0] to_c(input logic [31:0] v);
    return CW'({1'b0, v});
  endfunction

  // {flag, a - b saturated}
  function automatic logic [CW:0] tr(input logic signed [CW-1:0] a,
                                     input logic signed [CW-1:0] b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} - {b[CW-1], b};
    if (s[CW] != s[CW-1]) return {1'b1, s[CW], {(CW-1){~s[CW]}}};
    return {1'b0, s[CW-1:0]};
  endfunction

  function automatic logic signed [SW-1:0] mul(input logic signed [16:0] t,
                                              input logic signed [CW-1:0] v);
    logic signed [SW-1:0] te;
    logic signed [SW-1:0] ve;
    te = SW'(t);
    ve = SW'(v);
    return te * ve;
  endfunction

  // {flag, round-half-up(s / 2^14) saturated}
  function automatic logic [CW:0] rs(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] r;
    logic [QW-1:0]        q;
    r = s + RND;
    q = r[SW-1:TRIG_FRAC];
    if (&q[QW-1:CW-1] || ~|q[QW-1:CW-1]) return {1'b0, q[CW-1:0]};
    return {1'b1, q[QW-1], {(CW-1){~q[QW-1]}}};
  endfunction

  logic signed [16:0] cx, sx, nsx, cy, sy, nsy, cz, sz, nsz;
  assign cx  = 17'($signed(trig_x_i[31:16]));
  assign sx  = 17'($signed(trig_x_i[15:0]));
  assign nsx = -sx;
  assign cy  = 17'($signed(trig_y_i[31:16]));
  assign sy  = 17'($signed(trig_y_i[15:0]));
  assign nsy = -sy;
  assign cz  = 17'($signed(trig_z_i[31:16]));
  assign sz  = 17'($signed(trig_z_i[15:0]));
  assign nsz = -sz;

  logic [NS-1:0] vld_q;
  logic          en;

  logic signed [CW-1:0] x0_q, y0_q, z0_q, z1_q, a2_q, b2_q, z2_q, b3_q;
  logic signed [CW-1:0] dx4_q, g4_q, b4_q, dx5_q, dx6_q, dy6_q, dz6_q;
  logic signed [SW-1:0] pa1_q, pa2_q, pb1_q, pb2_q;
  logic signed [SW-1:0] pd1_q, pd2_q, pg1_q, pg2_q;
  logic signed [SW-1:0] py1_q, py2_q, pz1_q, pz2_q;
  logic [NS-1:0]        fl_q;

  logic [CW:0] tx, ty, tz, ra, rb, rd, rg, ry, rz;

  assign en          = !vld_q[NS-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NS-1];
  assign out_o       = {fl_q[NS-1], dz6_q, dy6_q, dx6_q};

  assign tx = tr(to_c(in_i.point_x), to_c(cam_x_i));
  assign ty = tr(to_c(in_i.point_y), to_c(cam_y_i));
  assign tz = tr(to_c(in_i.point_z), to_c(cam_z_i));
  assign ra = rs(pa1_q + pa2_q);
  assign rb = rs(pb1_q + pb2_q);
  assign rd = rs(pd1_q + pd2_q);
  assign rg = rs(pg1_q + pg2_q);
  assign ry = rs(py1_q + py2_q);
  assign rz = rs(pz1_q + pz2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q  <= tx[CW-1:0];
      y0_q  <= ty[CW-1:0];
      z0_q  <= tz[CW-1:0];
      fl_q[0] <= tx[CW] | ty[CW] | tz[CW];
      // about z
      pa1_q <= mul(sz, y0_q);
      pa2_q <= mul(cz, x0_q);
      pb1_q <= mul(cz, y0_q);
      pb2_q <= mul(nsz, x0_q);
      z1_q  <= z0_q;
      fl_q[1] <= fl_q[0];
      a2_q  <= ra[CW-1:0];
      b2_q  <= rb[CW-1:0];
      z2_q  <= z1_q;
      fl_q[2] <= fl_q[1] | ra[CW] | rb[CW];
      // about y
      pd1_q <= mul(cy, a2_q);
      pd2_q <= mul(nsy, z2_q);
      pg1_q <= mul(cy, z2_q);
      pg2_q <= mul(sy, a2_q);
      b3_q  <= b2_q;
      fl_q[3] <= fl_q[2];
      dx4_q <= rd[CW-1:0];
      g4_q  <= rg[CW-1:0];
      b4_q  <= b3_q;
      fl_q[4] <= fl_q[3] | rd[CW] | rg[CW];
      // about x
      py1_q <= mul(sx, g4_q);
      py2_q <= mul(cx, b4_q);
      pz1_q <= mul(cx, g4_q);
      pz2_q <= mul(nsx, b4_q);
      dx5_q <= dx4_q;
      fl_q[5] <= fl_q[4];
      dx6_q <= dx5_q;
      dy6_q <= ry[CW-1:0];
      dz6_q <= rz[CW-1:0];
      fl_q[6] <= fl_q[5] | ry[CW] | rz[CW];
    end
  end

endmodule

// ----- hdl/ppp_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_fifo
// Short queue between the rotation front and the divide back.
// ----------------------------------------------------------------------------
module ppp_fifo #(
  parameter int W = 97
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [W-1:0] in_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_o
);
  import ppp_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);

  logic [W-1:0]  mem_q [FIFO_DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [AW:0]   cnt_q;
  logic          push, pop;

  assign in_ready_o  = cnt_q != (AW+1)'(FIFO_DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign out_o       = mem_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop)  rptr_q <= rptr_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= in_i;
  end

endmodule

// ----- hdl/ppp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_back
// Back pipeline: magnitude product, restoring divide one bit a stage,
// sign, saturation and screen offset.
// ----------------------------------------------------------------------------
module ppp_back #(
  parameter int CW = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [3*CW:0]        in_i,
  input  logic [31:0]          focal_i,
  input  logic signed [CW-1:0] off_x_i,
  input  logic signed [CW-1:0] off_y_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ppp_pkg::result_t     out_o
);
  import ppp_pkg::*;

  localparam int H  = (CW + 1) / 2;
  localparam int PW = 2 * H;
  localparam int UW = 4 * H;
  localparam int NW = 2 * CW;
  localparam int NS = CW + 6;

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
    return v[CW-1] ? -v : v;
  endfunction

  function automatic logic [PW-1:0] pp(input logic [H-1:0] a, input logic [H-1:0] b);
    logic [PW-1:0] ae;
    logic [PW-1:0] be;
    ae = PW'(a);
    be = PW'(b);
    return ae * be;
  endfunction

  // {flag, signed quotient saturated}
  function automatic logic [CW:0] fin(input logic [CW-1:0] q, input logic neg,
                                      input logic ovf);
    if (neg) begin
      if (ovf || (q[CW-1] && |q[CW-2:0])) return {2'b11, {(CW-1){1'b0}}};
      return {1'b0, -q};
    end
    if (ovf || q[CW-1]) return {2'b10, {(CW-1){1'b1}}};
    return {1'b0, q};
  endfunction

  function automatic logic [CW:0] addsat(input logic signed [CW-1:0] a,
                                         input logic signed [CW-1:0] b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    if (s[CW] != s[CW-1]) return {1'b1, s[CW], {(CW-1){~s[CW]}}};
    return {1'b0, s[CW-1:0]};
  endfunction

  logic [NS-1:0] vld_q;
  logic          en;

  logic signed [CW-1:0] dx, dy, dz, f;
  assign dx = in_i[CW-1:0];
  assign dy = in_i[2*CW-1:CW];
  assign dz = in_i[3*CW-1:2*CW];
  assign f  = CW'({1'b0, focal_i});

  // stage 0: magnitudes and signs
  logic [CW-1:0]        ma0_q, mx0_q, my0_q;
  // side data carried along all stages up to the divide
  logic [CW-1:0]        den0_q, den1_q, den2_q;
  logic [1:0]           neg0_q, neg1_q, neg2_q;
  logic signed [CW-1:0] dz0_q, dz1_q, dz2_q;
  logic                 fl0_q, fl1_q, fl2_q;
  // stage 1: partial products
  logic [PW-1:0]        xll_q, xlh_q, xhl_q, xhh_q, yll_q, ylh_q, yhl_q, yhh_q;
  // stage 2: numerators
  logic [NW-1:0]        nx2_q, ny2_q;
  // divide stages
  logic [CW-1:0]        rx_q [CW+1];
  logic [CW-1:0]        lx_q [CW+1];
  logic [CW-1:0]        ry_q [CW+1];
  logic [CW-1:0]        ly_q [CW+1];
  logic [CW-1:0]        dn_q [CW+1];
  logic [1:0]           ng_q [CW+1];
  logic [1:0]           ov_q [CW+1];
  logic signed [CW-1:0] dzd_q [CW+1];
  logic                 fld_q [CW+1];
  logic [CW-1:0]        rx_n [CW+1];
  logic [CW-1:0]        lx_n [CW+1];
  logic [CW-1:0]        ry_n [CW+1];
  logic [CW-1:0]        ly_n [CW+1];
  // tail
  logic signed [CW-1:0] vx_q, vy_q, dzf_q, sx_q, sy_q, dzo_q;
  logic                 fvx_q, fvy_q, flf_q, zd_q, flo_q;

  logic [UW-1:0] sumx, sumy;
  logic [CW:0]   qx, qy, ox, oy;
  logic          zdf;

  assign en          = !vld_q[NS-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NS-1];

  assign sumx = UW'(xll_q) + (UW'(xlh_q) << H) + (UW'(xhl_q) << H)
              + (UW'(xhh_q) << (2 * H)) + UW'(den1_q >> 1);
  assign sumy = UW'(yll_q) + (UW'(ylh_q) << H) + (UW'(yhl_q) << H)
              + (UW'(yhh_q) << (2 * H)) + UW'(den1_q >> 1);

  always_comb begin
    logic [CW:0] t;
    rx_n[0] = '0;
    lx_n[0] = '0;
    ry_n[0] = '0;
    ly_n[0] = '0;
    for (int k = 1; k <= CW; k++) begin
      t = {rx_q[k-1], lx_q[k-1][CW-1]};
      if (t >= {1'b0, dn_q[k-1]}) begin
        rx_n[k] = CW'(t - {1'b0, dn_q[k-1]});
        lx_n[k] = {lx_q[k-1][CW-2:0], 1'b1};
      end else begin
        rx_n[k] = t[CW-1:0];
        lx_n[k] = {lx_q[k-1][CW-2:0], 1'b0};
      end
      t = {ry_q[k-1], ly_q[k-1][CW-1]};
      if (t >= {1'b0, dn_q[k-1]}) begin
        ry_n[k] = CW'(t - {1'b0, dn_q[k-1]});
        ly_n[k] = {ly_q[k-1][CW-2:0], 1'b1};
      end else begin
        ry_n[k] = t[CW-1:0];
        ly_n[k] = {ly_q[k-1][CW-2:0], 1'b0};
      end
    end
  end

  assign qx  = fin(lx_q[CW], ng_q[CW][0], ov_q[CW][0]);
  assign qy  = fin(ly_q[CW], ng_q[CW][1], ov_q[CW][1]);
  assign ox  = addsat(vx_q, off_x_i);
  assign oy  = addsat(vy_q, off_y_i);
  assign zdf = dzf_q == '0;

  assign out_o.screen_x   = 32'(sx_q);
  assign out_o.screen_y   = 32'(sy_q);
  assign out_o.depth      = 32'(dzo_q);
  assign out_o.zero_depth = zd_q;
  assign out_o.saturated  = flo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ma0_q  <= mag(f);
      mx0_q  <= mag(dx);
      my0_q  <= mag(dy);
      den0_q <= mag(dz);
      neg0_q <= {f[CW-1] ^ dy[CW-1] ^ dz[CW-1], f[CW-1] ^ dx[CW-1] ^ dz[CW-1]};
      dz0_q  <= dz;
      fl0_q  <= in_i[3*CW];

      xll_q <= pp(ma0_q[H-1:0], mx0_q[H-1:0]);
      xlh_q <= pp(ma0_q[H-1:0], H'(mx0_q >> H));
      xhl_q <= pp(H'(ma0_q >> H), mx0_q[H-1:0]);
      xhh_q <= pp(H'(ma0_q >> H), H'(mx0_q >> H));
      yll_q <= pp(ma0_q[H-1:0], my0_q[H-1:0]);
      ylh_q <= pp(ma0_q[H-1:0], H'(my0_q >> H));
      yhl_q <= pp(H'(ma0_q >> H), my0_q[H-1:0]);
      yhh_q <= pp(H'(ma0_q >> H), H'(my0_q >> H));
      den1_q <= den0_q;
      neg1_q <= neg0_q;
      dz1_q  <= dz0_q;
      fl1_q  <= fl0_q;

      nx2_q  <= sumx[NW-1:0];
      ny2_q  <= sumy[NW-1:0];
      den2_q <= den1_q;
      neg2_q <= neg1_q;
      dz2_q  <= dz1_q;
      fl2_q  <= fl1_q;

      // quotient must fit CW bits, else it saturates anyway
      rx_q[0]  <= nx2_q[NW-1:CW];
      lx_q[0]  <= nx2_q[CW-1:0];
      ry_q[0]  <= ny2_q[NW-1:CW];
      ly_q[0]  <= ny2_q[CW-1:0];
      ov_q[0]  <= {ny2_q[NW-1:CW] >= den2_q, nx2_q[NW-1:CW] >= den2_q};
      dn_q[0]  <= den2_q;
      ng_q[0]  <= neg2_q;
      dzd_q[0] <= dz2_q;
      fld_q[0] <= fl2_q;
      for (int k = 1; k <= CW; k++) begin
        rx_q[k]  <= rx_n[k];
        lx_q[k]  <= lx_n[k];
        ry_q[k]  <= ry_n[k];
        ly_q[k]  <= ly_n[k];
        ov_q[k]  <= ov_q[k-1];
        dn_q[k]  <= dn_q[k-1];
        ng_q[k]  <= ng_q[k-1];
        dzd_q[k] <= dzd_q[k-1];
        fld_q[k] <= fld_q[k-1];
      end

      vx_q  <= qx[CW-1:0];
      vy_q  <= qy[CW-1:0];
      fvx_q <= qx[CW];
      fvy_q <= qy[CW];
      dzf_q <= dzd_q[CW];
      flf_q <= fld_q[CW];

      sx_q  <= zdf ? off_x_i : ox[CW-1:0];
      sy_q  <= zdf ? off_y_i : oy[CW-1:0];
      dzo_q <= dzf_q;
      zd_q  <= zdf;
      flo_q <= flf_q | (!zdf & (fvx_q | fvy_q | ox[CW] | oy[CW]));
    end
  end

endmodule

// ----- hdl/perspective_point_projection.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_point_projection
// Fixed-point camera transform and perspective divide of one 3D point.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid_i/in_ready_o, one world point per beat.
//   out channel : out_valid_o/out_ready_i, one screen result per beat.
//   cfg channel : cfg_valid_i/cfg_ready_o, index and data; always ready.
//                 Write only while no point is in flight.
//   Throughput is one point per cycle unless the receiver stalls. A point
//   passes seven rotation stages, the queue, and a divide that retires
//   one quotient bit per stage.
//   When the receiver stalls, the back pipeline holds, the four-entry queue
//   fills, and then the front stops taking input.
//   Reset empties every stage and the queue and loads the registers with
//   an identity camera: no translation, cosine one, sine zero, focal 1.0.
// ----------------------------------------------------------------------------
module perspective_point_projection #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ppp_pkg::point_t                 in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ppp_pkg::result_t                out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ppp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [63:0]                     cfg_data_i
);
  import ppp_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int OW = (CW < 32) ? CW : 32;
  localparam int MW = 3 * CW + 1;
  localparam logic [31:0] FOCAL_RST = 32'(64'd1 << FRAC_BITS);

  logic [31:0] cam_x_q, cam_y_q, cam_z_q, rot_x_q, rot_y_q, rot_z_q, focal_q;
  logic [63:0] offset_q;

  logic signed [CW-1:0] off_x_c, off_y_c;

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [MW-1:0] f_data, b_data;

  assign cfg_ready_o = 1'b1;
  assign off_x_c     = CW'($signed(offset_q[32+OW-1:32]));
  assign off_y_c     = CW'($signed(offset_q[OW-1:0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q  <= '0;
      cam_y_q  <= '0;
      cam_z_q  <= '0;
      rot_x_q  <= TRIG_RST;
      rot_y_q  <= TRIG_RST;
      rot_z_q  <= TRIG_RST;
      offset_q <= '0;
      focal_q  <= FOCAL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CAMERA_X:  cam_x_q  <= cfg_data_i[31:0];
        REG_CAMERA_Y:  cam_y_q  <= cfg_data_i[31:0];
        REG_CAMERA_Z:  cam_z_q  <= cfg_data_i[31:0];
        REG_ROT_X:     rot_x_q  <= cfg_data_i[31:0];
        REG_ROT_Y:     rot_y_q  <= cfg_data_i[31:0];
        REG_ROT_Z:     rot_z_q  <= cfg_data_i[31:0];
        REG_SCREEN_OF: offset_q <= cfg_data_i;
        REG_FOCAL:     focal_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  ppp_front #(.CW(CW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .cam_x_i     (cam_x_q),
    .cam_y_i     (cam_y_q),
    .cam_z_i     (cam_z_q),
    .trig_x_i    (rot_x_q),
    .trig_y_i    (rot_y_q),
    .trig_z_i    (rot_z_q),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_o       (f_data)
  );

  ppp_fifo #(.W(MW)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_i        (f_data),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_o       (b_data)
  );

  ppp_back #(.CW(CW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_valid),
    .in_ready_o  (b_ready),
    .in_i        (b_data),
    .focal_i     (focal_q),
    .off_x_i     (off_x_c),
    .off_y_i     (off_y_c),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  a_zd_off_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.zero_depth |-> out_o.screen_x == 32'(off_x_c))
    else $error("zero depth beat without x offset");

  a_zd_off_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.zero_depth |-> out_o.screen_y == 32'(off_y_c))
    else $error("zero depth beat without y offset");

  a_zd_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.zero_depth |-> out_o.depth == '0)
    else $error("zero depth flag with nonzero depth");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the perspective point projector. A queue of world
// points feeds a bursty driver; a monitor compares each screen result beat
// with the value worked out by a fixed-point projection written in the bench.
// The camera registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import ppp_pkg::*;

  localparam int LATENCY   = 46;
  localparam int WATCHDOG  = 20000;
  localparam int RAND_PTS  = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  point_t in_pt = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  result_t out_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  perspective_point_projection u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_i(in_pt),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_o(out_res),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // camera copy
  logic signed [31:0] cam_x, cam_y, cam_z, focal;
  logic [31:0] trig_x, trig_y, trig_z;
  logic [63:0] offsets;

  point_t  pending_pts[$];
  result_t expected_res[$];

  int mismatches = 0;
  int results_seen = 0;
  int zero_depth_seen = 0;
  int sat_seen = 0;
  int idle_cycles = 0;
  int drv_burst = 0;
  int drv_gap = 0;
  int hold_off = 0;
  bit hold_req = 1'b0;

  function automatic logic signed [63:0] clip(input logic signed [63:0] v,
                                              inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic signed [63:0] rotate_pair(
      input logic signed [63:0] t1, v1, t2, v2, inout bit flag);
    logic signed [63:0] s;
    s = t1 * v1 + t2 * v2;
    s = (s + 64'sd8192) >>> TRIG_FRAC;
    return clip(s, flag);
  endfunction

  function automatic logic signed [63:0] divide_round(
      input logic signed [63:0] f, d, dz, inout bit flag);
    logic [127:0] num, q;
    logic [63:0] den;
    logic signed [63:0] r;
    bit neg;
    num = 128'(f < 0 ? -f : f) * 128'(d < 0 ? -d : d);
    den = dz < 0 ? -dz : dz;
    num = num + 128'(den >> 1);
    q = num / 128'(den);
    if (q > 128'(64'h4000_0000_0000_0000)) q = 128'(64'h4000_0000_0000_0000);
    neg = ((f < 0) != (d < 0)) != (dz < 0);
    r = neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    return clip(r, flag);
  endfunction

  function automatic result_t project_point(input point_t p);
    result_t r;
    bit flag;
    logic signed [63:0] cxr, sxr, cyr, syr, czr, szr, x, y, z;
    logic signed [63:0] a, b, dx, g, dy, dz, sx, sy, offx, offy;
    flag = 1'b0;
    cxr = $signed(trig_x[31:16]); sxr = $signed(trig_x[15:0]);
    cyr = $signed(trig_y[31:16]); syr = $signed(trig_y[15:0]);
    czr = $signed(trig_z[31:16]); szr = $signed(trig_z[15:0]);
    offx = $signed(offsets[63:32]);
    offy = $signed(offsets[31:0]);
    x = clip(64'(p.point_x) - 64'(cam_x), flag);
    y = clip(64'(p.point_y) - 64'(cam_y), flag);
    z = clip(64'(p.point_z) - 64'(cam_z), flag);
    a  = rotate_pair(szr, y, czr, x, flag);
    b  = rotate_pair(czr, y, -szr, x, flag);
    dx = rotate_pair(cyr, a, -syr, z, flag);
    g  = rotate_pair(cyr, z, syr, a, flag);
    dy = rotate_pair(sxr, g, cxr, b, flag);
    dz = rotate_pair(cxr, g, -sxr, b, flag);
    if (dz == 0) begin
      sx = offx;
      sy = offy;
    end else begin
      sx = clip(divide_round(64'(focal), dx, dz, flag) + offx, flag);
      sy = clip(divide_round(64'(focal), dy, dz, flag) + offy, flag);
    end
    r.screen_x   = sx[31:0];
    r.screen_y   = sy[31:0];
    r.depth      = dz[31:0];
    r.zero_depth = (dz == 0);
    r.saturated  = flag;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom;
      3: return 32'($signed($urandom_range(0, 8'hff) - 128) <<< 16);
      default: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_trig();
    if ($urandom_range(0, 3) == 0) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'h4000_0000;
      1: return 32'h0000_4000;
      2: return 32'hc000_0000;
      3: return {16'h2d41, 16'h2d41};
      default: return {16'h3b21, 16'h187e};
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CAMERA_X:  cam_x   = val[31:0];
      REG_CAMERA_Y:  cam_y   = val[31:0];
      REG_CAMERA_Z:  cam_z   = val[31:0];
      REG_ROT_X:     trig_x  = val[31:0];
      REG_ROT_Y:     trig_y  = val[31:0];
      REG_ROT_Z:     trig_z  = val[31:0];
      REG_SCREEN_OF: offsets = val;
      default:       focal   = val[31:0];
    endcase
  endtask

  task automatic queue_point(input logic [31:0] x, y, z);
    point_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    pending_pts.push_back(p);
  endtask

  task automatic drain();
    wait (pending_pts.size() == 0 && !in_valid && expected_res.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // driver: bursts with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_res.push_back(project_point(in_pt));
      end
      if (!in_valid || in_ready) begin
        if (drv_gap > 0) begin
          drv_gap <= drv_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_pts.size() > 0) begin
          in_pt <= pending_pts.pop_front();
          in_valid <= 1'b1;
          if (drv_burst == 0) begin
            drv_burst <= $urandom_range(1, 40);
            drv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            drv_burst <= drv_burst - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern and monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_req && hold_off == 0) begin
        hold_off <= 300;
        hold_req <= 1'b0;
        out_ready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= (hold_off == 1);
      end else begin
        out_ready <= ($urandom_range(0, 99) < 70) || (results_seen % 128 > 96);
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat %p", out_res);
        end else begin
          result_t e;
          e = expected_res.pop_front();
          if (out_res.zero_depth) zero_depth_seen++;
          if (out_res.saturated) sat_seen++;
          if (out_res !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected x=%h y=%h d=%h zd=%b sat=%b, ",
                        "got x=%h y=%h d=%h zd=%b sat=%b"},
                       e.screen_x, e.screen_y, e.depth, e.zero_depth, e.saturated,
                       out_res.screen_x, out_res.screen_y, out_res.depth,
                       out_res.zero_depth, out_res.saturated);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_valid)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("[perspective_point_projection] ERROR");
        $finish;
      end
    end
  end

  initial begin
    cam_x = '0; cam_y = '0; cam_z = '0;
    trig_x = TRIG_RST; trig_y = TRIG_RST; trig_z = TRIG_RST;
    offsets = '0;
    focal = 32'sh0001_0000;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset camera
    queue_point(32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
    queue_point('0, '0, '0);
    queue_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001);
    queue_point(32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
    queue_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    queue_point(32'h0000_0001, 32'hffff_ffff, 32'h8000_0000);
    queue_point(32'h0003_0000, 32'hfffd_0000, 32'h0000_0002);
    queue_point(32'hffff_8000, 32'h0000_8000, 32'hffff_ffff);
    drain();

    // directed, extreme camera
    write_reg(REG_CAMERA_X, 64'h7fff_ffff);
    write_reg(REG_CAMERA_Y, 64'h8000_0000);
    write_reg(REG_CAMERA_Z, 64'h0001_0000);
    write_reg(REG_ROT_X, 64'h2d41_2d41);
    write_reg(REG_ROT_Y, 64'h8000_7fff);
    write_reg(REG_ROT_Z, 64'h7fff_8000);
    write_reg(REG_SCREEN_OF, 64'h7fff_ffff_8000_0000);
    write_reg(REG_FOCAL, 64'h8000_0000);
    queue_point(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);
    queue_point(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    queue_point('0, '0, 32'h0001_0000);
    queue_point(32'h0123_4567, 32'hfedc_ba98, 32'h7fff_ffff);
    drain();
    write_reg(REG_FOCAL, 64'h7fff_ffff);
    write_reg(REG_SCREEN_OF, 64'h8000_0000_7fff_ffff);
    queue_point(32'h7fff_fff0, 32'h8000_0010, 32'h0001_0001);
    queue_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    hold_req = 1'b1;
    for (int i = 0; i < 100; i++)
      queue_point(rand_coord(), rand_coord(), rand_coord());
    drain();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_CAMERA_X, 64'(rand_coord()));
      write_reg(REG_CAMERA_Y, 64'(rand_coord()));
      write_reg(REG_CAMERA_Z, 64'(rand_coord()));
      write_reg(REG_ROT_X, 64'(rand_trig()));
      write_reg(REG_ROT_Y, 64'(rand_trig()));
      write_reg(REG_ROT_Z, 64'(rand_trig()));
      write_reg(REG_SCREEN_OF, {rand_coord(), rand_coord()});
      write_reg(REG_FOCAL, (ph == 0) ? 64'h0 : 64'(rand_coord()));
      for (int i = 0; i < RAND_PTS / 8; i++) begin
        if ($urandom_range(0, 9) == 0)
          queue_point(cam_x, cam_y, cam_z);
        else
          queue_point(rand_coord(), rand_coord(), rand_coord());
      end
      drain();
    end

    $display("covered %0d result beats, %0d with zero depth, %0d saturated",
             results_seen, zero_depth_seen, sat_seen);
    $display("%0d mismatches across eleven register settings", mismatches);
    if (mismatches == 0)
      $display("[perspective_point_projection] OK");
    else
      $display("[perspective_point_projection] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/ppp_pkg.sv
hdl/ppp_front.sv
hdl/ppp_fifo.sv
hdl/ppp_back.sv
hdl/perspective_point_projection.sv
sim/tb_top.sv
